>>> rtl/mpbp_pkg.sv
// Shared constants, types and widths of the map and position byte parser.
package mpbp_pkg;

    localparam int MAP_CELLS_DEF = 192;
    localparam int CNT_W         = 13;
    localparam int IDX_W         = 12;
    localparam int KIND_W        = 3;
    localparam int BYTE_W        = 8;
    localparam int MODE_W        = 2;
    localparam int VAL_W         = 16;
    localparam int RIDX_W        = 8;
    localparam int RID_W         = 4;
    localparam int CELL_W        = 3;
    localparam int TDATA_OUT_W   = 64;

    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MAP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POS    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TARGET = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BOX    = 3'd4;

    localparam logic [MODE_W-1:0] MODE_TARGET = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOX    = 2'd2;

    localparam logic [BYTE_W-1:0] CHAR_X    = 8'h58;
    localparam logic [BYTE_W-1:0] CHAR_Y    = 8'h59;
    localparam logic [BYTE_W-1:0] CHAR_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9    = 8'h39;
    localparam logic [BYTE_W-1:0] CELL_MAX  = 8'd5;
    localparam logic [BYTE_W-1:0] ID_MAX    = 8'd9;
    localparam logic [VAL_W-1:0]  VAL_SAT   = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_X    = 3'b010,
        PH_Y    = 3'b100
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  map_index;
        logic [CELL_W-1:0] map_cell;
        logic              map_last;
        logic [VAL_W-1:0]  pos_x;
        logic [VAL_W-1:0]  pos_y;
        logic [RIDX_W-1:0] recog_index;
        logic [RID_W-1:0]  recog_id;
    } result_t;

    function automatic logic [VAL_W-1:0] dec_sat(input logic [VAL_W-1:0] acc,
                                                 input logic [BYTE_W-1:0] chr);
        logic [VAL_W+3:0] sum;
        logic [BYTE_W-1:0] dig;
        dig = chr - CHAR_0;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(VAL_W-4){1'b0}}, dig};
        dec_sat = (sum > {4'b0000, VAL_SAT}) ? VAL_SAT : sum[VAL_W-1:0];
    endfunction

endpackage

>>> rtl/mpbp_decode.sv
// Parser state and the combinational decode of one byte into one result.
module mpbp_decode import mpbp_pkg::*; #(
    parameter int MAP_CELLS = MAP_CELLS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [MODE_W-1:0] mode,
    output result_t           res
);

    localparam logic [CNT_W-1:0] MAP_CELLS_C = CNT_W'(MAP_CELLS);

    logic [CNT_W-1:0]  cells_reg, cells_next;
    phase_t            phase_reg, phase_next;
    logic [VAL_W-1:0]  x_reg, x_next;
    logic [VAL_W-1:0]  y_reg, y_next;
    logic [RIDX_W-1:0] target_reg, target_next;
    logic [RIDX_W-1:0] box_reg, box_next;
    logic              is_digit;
    logic [CNT_W-1:0]  cells_inc;

    assign is_digit  = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
    assign cells_inc = cells_reg + CNT_W'(1);

    always_comb begin
        res         = '0;
        res.kind    = KIND_NONE;
        cells_next  = cells_reg;
        phase_next  = phase_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        target_next = target_reg;
        box_next    = box_reg;
        if ((cells_reg < MAP_CELLS_C) && (rx_byte <= CELL_MAX)) begin
            res.kind      = KIND_MAP;
            res.map_index = cells_reg[IDX_W-1:0];
            res.map_cell  = rx_byte[CELL_W-1:0];
            res.map_last  = (cells_inc == MAP_CELLS_C);
            cells_next    = cells_inc;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (rx_byte == CHAR_X) begin
                        phase_next = PH_X;
                        x_next     = '0;
                        y_next     = '0;
                    end else if (rx_byte <= ID_MAX) begin
                        if (mode == MODE_TARGET) begin
                            res.kind        = KIND_TARGET;
                            res.recog_index = target_reg;
                            res.recog_id    = rx_byte[RID_W-1:0];
                            target_next     = target_reg + RIDX_W'(1);
                        end else if (mode == MODE_BOX) begin
                            res.kind        = KIND_BOX;
                            res.recog_index = box_reg;
                            res.recog_id    = rx_byte[RID_W-1:0];
                            box_next        = box_reg + RIDX_W'(1);
                        end
                    end
                end
                PH_X: begin
                    if (is_digit) begin
                        x_next = dec_sat(x_reg, rx_byte);
                    end else if (rx_byte == CHAR_Y) begin
                        phase_next = PH_Y;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_Y: begin
                    if (is_digit) begin
                        y_next = dec_sat(y_reg, rx_byte);
                    end else if (rx_byte == CHAR_A) begin
                        phase_next = PH_IDLE;
                        res.kind   = KIND_POS;
                        res.pos_x  = x_reg;
                        res.pos_y  = y_reg;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cells_reg  <= '0;
            phase_reg  <= PH_IDLE;
            x_reg      <= '0;
            y_reg      <= '0;
            target_reg <= '0;
            box_reg    <= '0;
        end else if (step) begin
            cells_reg  <= cells_next;
            phase_reg  <= phase_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            target_reg <= target_next;
            box_reg    <= box_next;
        end
    end

    a_cells_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cells_reg <= MAP_CELLS_C)
        else $error("map cell count ran past the map size");

    a_cells_move: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.kind == KIND_MAP |=> cells_reg == $past(cells_reg) + CNT_W'(1))
        else $error("map cell count did not advance with a map cell");

    a_cells_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.kind != KIND_MAP |=> $stable(cells_reg))
        else $error("map cell count moved without a map cell");

endmodule

>>> rtl/map_and_position_byte_parser_unit.sv
// Top level of the map and position byte parser: stream ports, mode register and pipeline.
//
// Each received word yields exactly one result word, including results of kind nothing.
// One word is accepted every clock cycle while s_tready is high; the result is presented
// once its word has passed the input register, the combinational decode and the result
// register. A stall on the result side stops the input side only once both registers are
// full. recognition_mode is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module map_and_position_byte_parser_unit import mpbp_pkg::*; #(
    parameter int MAP_CELLS = MAP_CELLS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // rx_byte [7:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // map_index [11:0], map_cell [14:12], pos_x [30:15], pos_y [46:31],
    // recog_index [54:47], recog_id [58:55], zero fill [63:59]
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic [KIND_W-1:0]      m_tuser,   // result_kind [2:0]
    output logic                   m_tlast,   // map_last
    input  logic                   cfg_we,
    input  logic [MODE_W-1:0]      cfg_wdata
);

    logic [MODE_W-1:0] mode_reg;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    result_t           dec_res;
    logic              advance;

    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    mpbp_decode #(
        .MAP_CELLS(MAP_CELLS)
    ) u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .mode    (mode_reg),
        .res     (dec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= dec_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.map_last;
    assign m_tdata  = {5'd0, out_reg.recog_id, out_reg.recog_index, out_reg.pos_y,
                       out_reg.pos_x, out_reg.map_cell, out_reg.map_index};

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input side stalled while the pipeline had room");

    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("decoded word did not reach the result register");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_MAP)
        else $error("last marker on a word that is not a map cell");

endmodule
